// ----- rtl/mac_pkg.sv -----
// Shared types and constants of the move-ahead counting predictor.
`default_nettype none

package mac_pkg;

   localparam int KEY_IN_W = 32;
   localparam int CAP_W    = 7;
   localparam int CNT_W    = 17;
   localparam int SLOT_W   = 6;
   localparam int OCC_W    = 7;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [CAP_W-1:0] CAP_MIN       = 7'd2;
   localparam int               CAP_RESET_MAX = 64;
   localparam logic [CNT_W-1:0] LIMIT_RESET   = 17'd16;
   localparam logic [CNT_W-1:0] LIMIT_MIN     = 17'd1;
   localparam logic [CNT_W-1:0] LIMIT_MAX     = 17'd65536;

   typedef enum logic [1:0] {
      ACT_HIT       = 2'd0,
      ACT_HIT_SAT   = 2'd1,
      ACT_MISS_FULL = 2'd2,
      ACT_INSERT    = 2'd3
   } mac_action_type;

   typedef enum logic {
      REG_CAPACITY    = 1'b0,
      REG_COUNT_LIMIT = 1'b1
   } mac_reg_type;

   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic [CNT_W-1:0] count_limit;
      logic             cap_load;
   } mac_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/mac_csr.sv -----
// Register block of the predictor: capacity and count limit behind an APB-style port.
`default_nettype none

module mac_csr import mac_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   input  logic              queue_empty,
   output mac_cfg_type       cfg
);

   localparam int CAP_RST = (DEPTH < CAP_RESET_MAX) ? DEPTH : CAP_RESET_MAX;

   logic [CAP_W-1:0] capacity_ff;
   logic [CNT_W-1:0] limit_ff;
   logic [CAP_W-1:0] cap_wdata;
   logic [CNT_W-1:0] limit_wdata;
   logic             wr_strobe;
   mac_reg_type      reg_sel;

   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite;
   assign reg_sel   = mac_reg_type'(paddr[2]);

   // clamp to the legal ranges
   always_comb begin
      if (pwdata[CAP_W-1:0] < CAP_MIN) begin
         cap_wdata = CAP_MIN;
      end else if (32'(pwdata[CAP_W-1:0]) > DEPTH) begin
         cap_wdata = CAP_W'(DEPTH);
      end else begin
         cap_wdata = pwdata[CAP_W-1:0];
      end
      if (pwdata[CNT_W-1:0] < LIMIT_MIN) begin
         limit_wdata = LIMIT_MIN;
      end else if (pwdata[CNT_W-1:0] > LIMIT_MAX) begin
         limit_wdata = LIMIT_MAX;
      end else begin
         limit_wdata = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RST);
         limit_ff    <= LIMIT_RESET;
      end else if (wr_strobe) begin
         case (reg_sel)
            REG_CAPACITY: begin
               if (queue_empty) begin
                  capacity_ff <= cap_wdata;
               end
            end
            REG_COUNT_LIMIT: begin
               limit_ff <= limit_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_CAPACITY:    prdata = DATA_W'(capacity_ff);
         REG_COUNT_LIMIT: prdata = DATA_W'(limit_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.capacity    = capacity_ff;
   assign cfg.count_limit = limit_ff;
   assign cfg.cap_load    = wr_strobe && (reg_sel == REG_CAPACITY) && queue_empty;

endmodule

`default_nettype wire

// ----- rtl/move_ahead_counting_predictor_top.sv -----
// Top level of the move-ahead counting predictor: entry memory, search sequencer, result register.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_ready  req_key
//   rsp       out         rsp_valid / rsp_ready  rsp_action, rsp_slot, rsp_occupancy,
//                                                rsp_is_empty, rsp_is_full
//   csr       in/out      psel / penable / pready paddr, pwdata, prdata
//
// One request at a time. It passes through an accept step, a compare of each valid entry
// (newest first, one memory read per cycle), then the swap, count update, tail decrement
// or insert, and a last step that loads the result; an empty ring skips the compare.
// One entry read per cycle sets the pace.
// Reset (synchronous) clears the pointers, empty flag and result valid at once; the entry
// memory is not cleared, only entries already written are ever compared or used.
// A stalled result waits in its register; the next request is taken meanwhile and holds
// in the last step until the result register frees up.
`default_nettype none

module move_ahead_counting_predictor_top import mac_pkg::*; #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KEY_IN_W-1:0] req_key,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_action,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [OCC_W-1:0]    rsp_occupancy,
   output logic                rsp_is_empty,
   output logic                rsp_is_full,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // wide enough for index + 1 and for the capacity
   localparam int CMP_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
   localparam int ENT_W = KEY_WIDTH + CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MISS,
      ST_SWAP_LO,
      ST_UPDATE,
      ST_TAIL_RD,
      ST_TAIL_WR,
      ST_DONE
   } state_type;

   // ring pointer helpers: indices stay below the capacity
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] s;
      s = CMP_W'(i) + CMP_W'(1);
      return (s >= CMP_W'(cap)) ? '0 : s[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] c;
      c = CMP_W'(cap) - CMP_W'(1);
      return (i == '0) ? c[IDX_W-1:0] : i - IDX_W'(1);
   endfunction

   function automatic logic [CMP_W-1:0] occupancy(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] tail,
                                                  input logic             empty,
                                                  input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] r;
      if (empty) begin
         r = '0;
      end else if (head > tail) begin
         r = CMP_W'(head) - CMP_W'(tail);
      end else begin
         r = CMP_W'(cap) - CMP_W'(tail) + CMP_W'(head);
      end
      return r;
   endfunction

   mac_cfg_type cfg;

   state_type        state_ff;
   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] tail_ff;
   logic             empty_ff;

   // per-request working registers
   logic [KEY_WIDTH-1:0] key_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;   // slot whose data sits in rd_data_ff
   logic [CMP_W-1:0]     remain_ff;    // entries still to compare after this one
   logic [ENT_W-1:0]     prev_ff;      // entry one place nearer the head
   logic [IDX_W-1:0]     pos_ff;
   logic [IDX_W-1:0]     dst_ff;
   logic [ENT_W-1:0]     upd_ff;
   logic                 sat_ff;
   mac_action_type       action_ff;
   logic [IDX_W-1:0]     slot_ff;

   // result register
   logic                 rsp_valid_ff;
   mac_action_type       rsp_action_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [OCC_W-1:0]     rsp_occ_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_full_ff;

   // entry memory
   logic [ENT_W-1:0] entry_mem_ff [DEPTH];
   logic [ENT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;

   logic [63:0]          key_wide;
   logic [KEY_WIDTH-1:0] key_masked;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [CNT_W-1:0]     rd_cnt;
   logic [CNT_W-1:0]     tail_dec;
   logic [IDX_W-1:0]     newest_idx;
   logic [IDX_W-1:0]     tail_next;
   logic [CMP_W-1:0]     occ_now;
   logic                 full_now;
   logic                 hit;
   logic                 hit_sat;
   logic                 hit_swap;
   logic [CMP_W-1:0]     slot_wide;

   mac_csr #(
      .DEPTH (DEPTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .queue_empty (empty_ff),
      .cfg         (cfg)
   );

   // keep only the low KEY_WIDTH bits of the key
   assign key_wide   = 64'(req_key);
   assign key_masked = key_wide[KEY_WIDTH-1:0];

   assign rd_key     = rd_data_ff[ENT_W-1:CNT_W];
   assign rd_cnt     = rd_data_ff[CNT_W-1:0];
   assign tail_dec   = (rd_cnt != '0) ? rd_cnt - CNT_W'(1) : '0;
   assign newest_idx = wrap_dec(head_ff, cfg.capacity);
   assign tail_next  = wrap_inc(tail_ff, cfg.capacity);
   assign occ_now    = occupancy(head_ff, tail_ff, empty_ff, cfg.capacity);
   assign full_now   = !empty_ff && (head_ff == tail_ff);
   assign hit        = (rd_key == key_ff);
   assign hit_sat    = (rd_cnt >= cfg.count_limit);
   assign hit_swap   = (cmp_idx_ff != newest_idx);
   assign slot_wide  = CMP_W'(slot_ff);

   assign req_ready  = (state_ff == ST_IDLE);

   // read address: newest entry while idle, next older one while searching, tail entry otherwise
   always_comb begin
      case (state_ff)
         ST_IDLE:   rd_addr = newest_idx;
         ST_SEARCH: rd_addr = wrap_dec(cmp_idx_ff, cfg.capacity);
         default:   rd_addr = tail_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tail_ff;
      wr_data = rd_data_ff;
      case (state_ff)
         ST_SWAP_LO: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = prev_ff;
         end
         ST_UPDATE: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            wr_data = upd_ff;
         end
         ST_TAIL_WR: begin
            wr_en   = 1'b1;
            wr_addr = tail_ff;
            wr_data = {rd_key, tail_dec};
         end
         ST_MISS: begin
            wr_en   = !full_now;
            wr_addr = head_ff;
            wr_data = {key_ff, CNT_W'(1)};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in the last step the result register is either kept or reloaded
         if (rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg.cap_load) begin
            head_ff <= '0;
            tail_ff <= '0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  key_ff     <= key_masked;
                  cmp_idx_ff <= newest_idx;
                  remain_ff  <= occ_now - CMP_W'(1);
                  state_ff   <= (occ_now == '0) ? ST_MISS : ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (hit) begin
                  pos_ff    <= cmp_idx_ff;
                  dst_ff    <= hit_swap ? wrap_inc(cmp_idx_ff, cfg.capacity) : cmp_idx_ff;
                  slot_ff   <= hit_swap ? wrap_inc(cmp_idx_ff, cfg.capacity) : cmp_idx_ff;
                  upd_ff    <= {key_ff, hit_sat ? rd_cnt : rd_cnt + CNT_W'(1)};
                  sat_ff    <= hit_sat;
                  action_ff <= hit_sat ? ACT_HIT_SAT : ACT_HIT;
                  state_ff  <= hit_swap ? ST_SWAP_LO : ST_UPDATE;
               end else if (remain_ff == '0) begin
                  state_ff <= ST_MISS;
               end else begin
                  prev_ff    <= rd_data_ff;
                  cmp_idx_ff <= wrap_dec(cmp_idx_ff, cfg.capacity);
                  remain_ff  <= remain_ff - CMP_W'(1);
               end
            end
            ST_MISS: begin
               if (full_now) begin
                  action_ff <= ACT_MISS_FULL;
                  slot_ff   <= '0;
                  state_ff  <= ST_TAIL_RD;
               end else begin
                  action_ff <= ACT_INSERT;
                  slot_ff   <= head_ff;
                  head_ff   <= wrap_inc(head_ff, cfg.capacity);
                  empty_ff  <= 1'b0;
                  state_ff  <= ST_DONE;
               end
            end
            ST_SWAP_LO: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               state_ff <= sat_ff ? ST_TAIL_RD : ST_DONE;
            end
            ST_TAIL_RD: begin
               state_ff <= ST_TAIL_WR;
            end
            ST_TAIL_WR: begin
               // a count that reaches zero retires the tail entry
               if (tail_dec == '0) begin
                  tail_ff <= tail_next;
                  if (tail_next == head_ff) begin
                     empty_ff <= 1'b1;
                  end
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_action_ff <= action_ff;
                  rsp_slot_ff   <= slot_wide[SLOT_W-1:0];
                  rsp_occ_ff    <= occ_now[OCC_W-1:0];
                  rsp_empty_ff  <= empty_ff;
                  rsp_full_ff   <= full_now;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_is_full   = rsp_full_ff;

endmodule

`default_nettype wire

// ----- rtl/mac_checker.sv -----
// Port-level checks of the predictor and their binding to the top level.
`default_nettype none

module mac_checker import mac_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_action,
   input logic [OCC_W-1:0] rsp_occupancy,
   input logic             rsp_is_empty,
   input logic             rsp_is_full
);

   // one request in flight: no second accept right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while one is in flight");

   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_occupancy == '0) && !rsp_is_full)
      else $error("empty result with entries or full flag");

   a_full_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_full |-> (rsp_occupancy != '0))
      else $error("full result with zero occupancy");

   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_INSERT) |-> !rsp_is_empty && (rsp_occupancy != '0))
      else $error("insert left the queue empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) && $stable(rsp_occupancy))
      else $error("stalled result changed");

endmodule

bind move_ahead_counting_predictor_top mac_checker u_mac_checker (.*);

`default_nettype wire
